// File: sv/cofc_pkg.sv
// ----------------------------------------------------------------------------
// cofc_pkg
// Shared types and codes of the CANopen frame classifier: function codes,
// message classes, decode kinds, presence and SDO flag positions, and the
// item that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package cofc_pkg;

  // Exact identifiers of the layer setting service
  localparam logic [10:0] LSS_SLAVE_ID  = 11'h7E4;
  localparam logic [10:0] LSS_MASTER_ID = 11'h7E5;

  // Function codes, identifier bits 10:7
  localparam logic [3:0] FC_NMT       = 4'd0;
  localparam logic [3:0] FC_EMCY_SYNC = 4'd1;
  localparam logic [3:0] FC_TIME      = 4'd2;
  localparam logic [3:0] FC_PDO_FIRST = 4'd3;
  localparam logic [3:0] FC_PDO_LAST  = 4'd10;
  localparam logic [3:0] FC_SDO_RX    = 4'd11;
  localparam logic [3:0] FC_SDO_TX    = 4'd12;
  localparam logic [3:0] FC_NMT_ERR   = 4'd14;

  // Message classes
  localparam logic [4:0] CLS_UNKNOWN    = 5'd0;
  localparam logic [4:0] CLS_EMCY       = 5'd4;
  localparam logic [4:0] CLS_SDO_RX     = 5'd13;
  localparam logic [4:0] CLS_SDO_TX     = 5'd14;
  localparam logic [4:0] CLS_NMT_ERR    = 5'd15;
  localparam logic [4:0] CLS_LSS_MASTER = 5'd16;
  localparam logic [4:0] CLS_LSS_SLAVE  = 5'd17;
  // NMT, SYNC and TIME follow the function code plus one, PDOs plus two
  localparam logic [4:0] CLS_BCAST_OFS  = 5'd1;
  localparam logic [4:0] CLS_PDO_OFS    = 5'd2;

  typedef enum logic [3:0] {
    KIND_NONE = 4'd0,
    KIND_NMT  = 4'd1,
    KIND_HB   = 4'd2,
    KIND_SYNC = 4'd3,
    KIND_TIME = 4'd4,
    KIND_EMCY = 4'd5,
    KIND_PDO  = 4'd6,
    KIND_SDO  = 4'd7,
    KIND_LSS  = 4'd8
  } kind_e;

  // Presence flag positions
  localparam int unsigned PF_PRI   = 0;
  localparam int unsigned PF_SEC   = 1;
  localparam int unsigned PF_IDX   = 2;
  localparam int unsigned PF_ABORT = 3;
  localparam int unsigned PF_DATA  = 4;
  localparam int unsigned PF_TRUNC = 5;
  localparam int unsigned PF_SHORT = 6;
  localparam int unsigned PF_VEND  = 7;
  localparam int unsigned PF_FD    = 8;

  // SDO flag positions
  localparam int unsigned SF_REQ   = 0;
  localparam int unsigned SF_RECOG = 1;
  localparam int unsigned SF_ABORT = 2;
  localparam int unsigned SF_SEG   = 3;
  localparam int unsigned SF_TOG   = 4;
  localparam int unsigned SF_LAST  = 5;
  localparam int unsigned SF_INIT  = 6;
  localparam int unsigned SF_EXP   = 7;
  localparam int unsigned SF_SIZE  = 8;
  localparam int unsigned SF_BLOCK = 9;

  // SDO command specifiers, byte 0 bits 7:5
  localparam logic [2:0] SDO_CS_SEG     = 3'd0;
  localparam logic [2:0] SDO_CS_INIT_DL = 3'd1;
  localparam logic [2:0] SDO_CS_INIT_UL = 3'd2;
  localparam logic [2:0] SDO_CS_SEG_UL  = 3'd3;
  localparam logic [2:0] SDO_CS_ABORT   = 3'd4;
  localparam logic [2:0] SDO_CS_BLK_UL  = 3'd5;
  localparam logic [2:0] SDO_CS_BLK_DL  = 3'd6;
  localparam logic [2:0] SDO_CS_RSVD    = 3'd7;

  localparam logic [3:0] MAX_PLEN = 4'd8;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        accepted;
    logic [4:0]  msg_class;
    logic [6:0]  node;
    logic [3:0]  fc;
    kind_e       kind;
    logic [3:0]  plen;
    logic [63:0] payload;
    logic        trunc;
    logic        fd;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// File: sv/cofc_if.sv
// ----------------------------------------------------------------------------
// cofc_if
// Channel interfaces: received CAN frame in, classification result out.
// ----------------------------------------------------------------------------
interface cofc_frame_if;
  logic        valid;
  logic        ready;
  logic [10:0] can_id;
  logic        extended_flag;
  logic        remote_flag;
  logic        error_flag;
  logic        fd_flag;
  logic [3:0]  payload_length;
  logic [63:0] payload_bytes;
  logic        capture_truncated;

  modport source (
    output valid, can_id, extended_flag, remote_flag, error_flag, fd_flag,
           payload_length, payload_bytes, capture_truncated,
    input  ready
  );
  modport sink (
    input  valid, can_id, extended_flag, remote_flag, error_flag, fd_flag,
           payload_length, payload_bytes, capture_truncated,
    output ready
  );
endinterface

interface cofc_class_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [4:0]  message_class;
  logic [6:0]  node_number;
  logic [3:0]  func_code;
  logic [3:0]  decode_kind;
  logic [31:0] primary_value;
  logic [15:0] secondary_value;
  logic [8:0]  presence_flags;
  logic [2:0]  sdo_command;
  logic [11:0] sdo_flags;
  logic [7:0]  sdo_subidx;
  logic [2:0]  sdo_nbytes;

  modport source (
    output valid, accepted, message_class, node_number, func_code, decode_kind,
           primary_value, secondary_value, presence_flags, sdo_command, sdo_flags,
           sdo_subidx, sdo_nbytes,
    input  ready
  );
  modport sink (
    input  valid, accepted, message_class, node_number, func_code, decode_kind,
           primary_value, secondary_value, presence_flags, sdo_command, sdo_flags,
           sdo_subidx, sdo_nbytes,
    output ready
  );
endinterface

// File: sv/cofc_front.sv
// ----------------------------------------------------------------------------
// cofc_front
// Front end: takes a frame, rejects extended, remote and error frames,
// splits the identifier, names the class and picks the payload decoder.
// ----------------------------------------------------------------------------
module cofc_front import cofc_pkg::*; (
  cofc_frame_if.sink frame_i,
  input  qstat_t     qstat_i,
  output logic       push_o,
  output item_t      item_o
);

  logic [10:0] id;
  logic [3:0]  fc;
  logic [6:0]  node;
  logic        reject;
  logic        is_lss;
  logic [4:0]  cls;
  kind_e       kind;

  assign frame_i.ready = ~qstat_i.full;
  assign push_o        = frame_i.valid & ~qstat_i.full;

  assign id     = frame_i.can_id;
  assign fc     = id[10:7];
  assign node   = id[6:0];
  assign reject = frame_i.extended_flag | frame_i.remote_flag | frame_i.error_flag;
  assign is_lss = (id == LSS_MASTER_ID) || (id == LSS_SLAVE_ID);

  always_comb begin
    cls = CLS_UNKNOWN;
    if (id == LSS_MASTER_ID) begin
      cls = CLS_LSS_MASTER;
    end else if (id == LSS_SLAVE_ID) begin
      cls = CLS_LSS_SLAVE;
    end else if (node == 7'd0) begin
      if (fc <= FC_TIME) cls = {1'b0, fc} + CLS_BCAST_OFS;
    end else if (fc == FC_EMCY_SYNC) begin
      cls = CLS_EMCY;
    end else if (fc >= FC_PDO_FIRST && fc <= FC_PDO_LAST) begin
      cls = {1'b0, fc} + CLS_PDO_OFS;
    end else if (fc == FC_SDO_RX) begin
      cls = CLS_SDO_RX;
    end else if (fc == FC_SDO_TX) begin
      cls = CLS_SDO_TX;
    end else if (fc == FC_NMT_ERR) begin
      cls = CLS_NMT_ERR;
    end
  end

  always_comb begin
    kind = KIND_NONE;
    if (frame_i.fd_flag) begin
      kind = KIND_NONE;
    end else if (is_lss) begin
      kind = KIND_LSS;
    end else if (fc == FC_NMT) begin
      kind = KIND_NMT;
    end else if (fc == FC_NMT_ERR) begin
      kind = KIND_HB;
    end else if (fc == FC_EMCY_SYNC && node == 7'd0) begin
      kind = KIND_SYNC;
    end else if (fc == FC_TIME) begin
      kind = KIND_TIME;
    end else if (fc == FC_EMCY_SYNC) begin
      kind = KIND_EMCY;
    end else if (fc >= FC_PDO_FIRST && fc <= FC_PDO_LAST) begin
      kind = KIND_PDO;
    end else if (fc == FC_SDO_RX || fc == FC_SDO_TX) begin
      kind = KIND_SDO;
    end
  end

  always_comb begin
    item_o = '0;
    if (!reject) begin
      item_o.accepted  = 1'b1;
      item_o.msg_class = cls;
      item_o.node      = node;
      item_o.fc        = fc;
      item_o.kind      = kind;
      // lengths above eight count as eight
      item_o.plen      = (frame_i.payload_length > MAX_PLEN) ? MAX_PLEN
                                                             : frame_i.payload_length;
      item_o.payload   = frame_i.payload_bytes;
      item_o.trunc     = frame_i.capture_truncated;
      item_o.fd        = frame_i.fd_flag;
    end
  end

endmodule

// File: sv/cofc_queue.sv
// ----------------------------------------------------------------------------
// cofc_queue
// Two-entry queue between the classifying front end and the decoding
// back end, so that either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module cofc_queue import cofc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  input  logic   pop_i,
  output item_t  item_o,
  output qstat_t qstat_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign qstat_o.full  = (count_q == QCNT_W'(QDEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign item_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != QCNT_W'(QDEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count lost a write");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

// File: sv/cofc_back.sv
// ----------------------------------------------------------------------------
// cofc_back
// Back end: decodes the payload of the queued frame (NMT, heartbeat, SYNC,
// time stamp, EMCY, SDO) and holds the result in the output register.
// ----------------------------------------------------------------------------
module cofc_back import cofc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  item_t       item_i,
  input  qstat_t      qstat_i,
  output logic        pop_o,
  cofc_class_if.source class_o
);

  logic [7:0]  b0, b1, b2, b3;
  logic [3:0]  plen;
  logic [31:0] pri;
  logic [15:0] sec;
  logic [8:0]  pf;
  logic [2:0]  cmd;
  logic [11:0] sfl;
  logic [7:0]  sub;
  logic [2:0]  sdl;

  // SDO working values
  logic [2:0]  cs;
  logic        req, seg_s, init_s, full_s, mux, abrt, active;
  logic [1:0]  blk_sub;
  logic [3:0]  dlen, off, skip, avail, act;

  logic        valid_q;
  logic        accepted_q;
  logic [4:0]  class_q;
  logic [6:0]  node_q;
  logic [3:0]  fc_q;
  logic [3:0]  kind_q;
  logic [31:0] pri_q;
  logic [15:0] sec_q;
  logic [8:0]  pf_q;
  logic [2:0]  cmd_q;
  logic [11:0] sfl_q;
  logic [7:0]  sub_q;
  logic [2:0]  sdl_q;

  assign b0   = item_i.payload[7:0];
  assign b1   = item_i.payload[15:8];
  assign b2   = item_i.payload[23:16];
  assign b3   = item_i.payload[31:24];
  assign plen = item_i.plen;

  // advance whenever the output register is free or being emptied
  assign pop_o = ~qstat_i.empty & (~valid_q | class_o.ready);

  always_comb begin
    pri = '0; sec = '0; pf = '0; cmd = '0; sfl = '0; sub = '0; sdl = '0;
    cs = b0[7:5];
    req = (item_i.fc == FC_SDO_RX);
    seg_s = 1'b0; init_s = 1'b0; full_s = 1'b0;
    mux = 1'b0; abrt = 1'b0; active = 1'b0;
    blk_sub = '0; dlen = '0; off = 4'd1; skip = 4'd1; avail = '0; act = '0;
    pf[PF_TRUNC] = item_i.trunc;
    pf[PF_FD]    = item_i.fd;

    unique case (item_i.kind)
      KIND_NMT: begin
        if (plen >= 4'd1) begin
          pri = {24'd0, b0};
          pf[PF_PRI] = 1'b1;
          if (plen >= 4'd2) begin
            sec = {8'd0, b1};
            pf[PF_SEC] = 1'b1;
          end
        end else begin
          pf[PF_SHORT] = 1'b1;
        end
      end
      KIND_HB: begin
        if (plen >= 4'd1) begin
          pri = {25'd0, b0[6:0]};
          sec = {15'd0, b0[7]};
          pf[PF_PRI] = 1'b1;
          pf[PF_SEC] = 1'b1;
        end
      end
      KIND_SYNC: begin
        if (plen >= 4'd1) begin
          pri = {24'd0, b0};
          pf[PF_PRI] = 1'b1;
        end
      end
      KIND_TIME: begin
        if (plen >= 4'd6) begin
          pri = item_i.payload[31:0];
          sec = item_i.payload[47:32];
          pf[PF_PRI] = 1'b1;
          pf[PF_SEC] = 1'b1;
        end else begin
          pf[PF_SHORT] = 1'b1;
        end
      end
      KIND_EMCY: begin
        if (plen >= 4'd3) begin
          pri = {16'd0, item_i.payload[15:0]};
          sec = {8'd0, b2};
          pf[PF_PRI]  = 1'b1;
          pf[PF_SEC]  = 1'b1;
          pf[PF_VEND] = (plen > 4'd3);
        end else begin
          pf[PF_SHORT] = 1'b1;
        end
      end
      KIND_SDO: begin
        if (plen == 4'd0) begin
          pf[PF_SHORT] = 1'b1;
        end else begin
          cmd = cs;
          sfl[SF_REQ]   = req;
          sfl[SF_RECOG] = (cs != SDO_CS_RSVD);
          seg_s  = req ? (cs == SDO_CS_SEG || cs == SDO_CS_SEG_UL)
                       : (cs == SDO_CS_SEG || cs == SDO_CS_INIT_DL);
          init_s = req ? (cs == SDO_CS_INIT_DL || cs == SDO_CS_INIT_UL)
                       : (cs == SDO_CS_INIT_UL || cs == SDO_CS_SEG_UL);
          full_s = (cs == SDO_CS_SEG) || (req && cs == SDO_CS_INIT_DL) ||
                   (!req && cs == SDO_CS_INIT_UL);
          if (cs == SDO_CS_ABORT) begin
            sfl[SF_ABORT] = 1'b1;
            mux    = 1'b1;
            abrt   = 1'b1;
            active = 1'b1;
          end else if (seg_s) begin
            sfl[SF_SEG] = 1'b1;
            sfl[SF_TOG] = b0[4];
            if (full_s) begin
              sfl[SF_LAST] = b0[0];
              dlen = 4'd7 - {1'b0, b0[3:1]};
            end
            active = 1'b1;
          end else if (init_s) begin
            sfl[SF_INIT] = 1'b1;
            mux = 1'b1;
            if (full_s) begin
              if (b0[1]) begin
                sfl[SF_EXP] = 1'b1;
                dlen = 4'd4 - {2'd0, b0[3:2]};
              end else begin
                dlen = 4'd4;
              end
              sfl[SF_SIZE] = b0[0];
            end
            active = 1'b1;
          end else if (cs == SDO_CS_BLK_UL || cs == SDO_CS_BLK_DL) begin
            blk_sub = (cs == SDO_CS_BLK_UL) ? b0[1:0] : {1'b0, b0[0]};
            sfl[SF_BLOCK] = 1'b1;
            sfl[11:10]    = blk_sub;
            mux  = (blk_sub == 2'd0);
            skip = mux ? 4'd4 : 4'd1;
            dlen = (plen > skip) ? plen - skip : 4'd0;
            active = 1'b1;
          end

          if (active) begin
            if (mux) begin
              if (plen >= 4'd4) begin
                sec = {b2, b1};
                sub = b3;
                pf[PF_SEC] = 1'b1;
                pf[PF_IDX] = 1'b1;
                off = 4'd4;
              end else begin
                pf[PF_SHORT] = 1'b1;
              end
            end
            if (abrt) begin
              // abort code sits in bytes 4..7 once the index is there
              if (plen >= off + 4'd4) begin
                pri = item_i.payload[63:32];
                pf[PF_PRI]   = 1'b1;
                pf[PF_ABORT] = 1'b1;
              end else begin
                pf[PF_SHORT] = 1'b1;
              end
            end else if (dlen != 4'd0 && plen >= off) begin
              avail = plen - off;
              act   = (dlen < avail) ? dlen : avail;
              if (act != 4'd0) begin
                pf[PF_DATA] = 1'b1;
                sdl = act[2:0];
                if (act < dlen) pf[PF_TRUNC] = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (class_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      accepted_q <= item_i.accepted;
      class_q    <= item_i.msg_class;
      node_q     <= item_i.node;
      fc_q       <= item_i.fc;
      kind_q     <= item_i.kind;
      pri_q      <= pri;
      sec_q      <= sec;
      pf_q       <= pf;
      cmd_q      <= cmd;
      sfl_q      <= sfl;
      sub_q      <= sub;
      sdl_q      <= sdl;
    end
  end

  assign class_o.valid           = valid_q;
  assign class_o.accepted        = accepted_q;
  assign class_o.message_class   = class_q;
  assign class_o.node_number     = node_q;
  assign class_o.func_code       = fc_q;
  assign class_o.decode_kind     = kind_q;
  assign class_o.primary_value   = pri_q;
  assign class_o.secondary_value = sec_q;
  assign class_o.presence_flags  = pf_q;
  assign class_o.sdo_command     = cmd_q;
  assign class_o.sdo_flags       = sfl_q;
  assign class_o.sdo_subidx      = sub_q;
  assign class_o.sdo_nbytes      = sdl_q;

endmodule

// File: sv/canopen_frame_classifier.sv
// ----------------------------------------------------------------------------
// canopen_frame_classifier
// CANopen frame classifier: one received CAN frame in, one classification
// out, with identifier split, message class and payload field decode.
//
//   Port      Dir   Carries
//   frame_i   in    CAN frame: identifier, flags, length, eight payload bytes
//   class_o   out   class, node, function code, decoded values, flags
//
// One frame per cycle while the queue is not full. A result is written to the
// queue at its transaction and goes to the output register once that is free.
// A two-entry queue parts front end and back end; the front end stalls only
// while it is full, which held output brings about when frames stream back to
// back. Reset empties the queue and the output register.
// ----------------------------------------------------------------------------
module canopen_frame_classifier import cofc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  cofc_frame_if.sink   frame_i,
  cofc_class_if.source class_o
);

  item_t  front_item;
  item_t  back_item;
  logic   push;
  logic   pop;
  qstat_t qstat;

  cofc_front u_front (
    .frame_i (frame_i),
    .qstat_i (qstat),
    .push_o  (push),
    .item_o  (front_item)
  );

  cofc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (back_item),
    .qstat_o (qstat)
  );

  cofc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (back_item),
    .qstat_i (qstat),
    .pop_o   (pop),
    .class_o (class_o)
  );

endmodule
